### rtl/pds_pkg.sv
// Package for the primitive depth sorter: opcodes, entry key layout, the
// cell command struct and key pack/unpack helpers. No dependencies.
`default_nettype none

package pds_pkg;

   localparam int CAPACITY    = 128;
   localparam int DEPTH_W     = 32;
   localparam int INDEX_W     = 10;
   localparam int KEY_W       = DEPTH_W + INDEX_W;
   localparam int DATA_W      = 48;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_USER_W  = 2;

   localparam logic [DEPTH_W-1:0] SIGN_BIAS = {1'b1, {(DEPTH_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic    insert;
      logic    pop;
      logic    clear;
      key_type key;
   } cell_cmd_type;

   // biased depth on top so an unsigned compare orders signed depths
   function automatic key_type pack_key(input logic [DEPTH_W-1:0] depth,
                                        input logic [INDEX_W-1:0] index);
      pack_key = {depth ^ SIGN_BIAS, index};
   endfunction

   function automatic logic [DEPTH_W-1:0] key_depth(input key_type key);
      key_depth = key[KEY_W-1:INDEX_W] ^ SIGN_BIAS;
   endfunction

   function automatic logic [INDEX_W-1:0] key_index(input key_type key);
      key_index = key[INDEX_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/primitive_depth_sorter_core.sv
// Top level of the primitive depth sorter: a chain of pds_cell instances
// plus command decode, overflow flag and a registered result stage.
// Depends on pds_pkg and pds_cell.
//
//  channel | dir | tdata                     | tuser
//  req     | in  | depth_key, prim_index     | opcode
//  rsp     | out | out_depth, out_index      | valid_res, overflowed
//
// One beat per cycle while req_tready is high: every cell compares against
// the broadcast key at once and shifts in step. A pop result is registered
// on acceptance. req_tready drops only while a result is held and
// rsp_tready is low. Synchronous reset empties the list; no clearing pass.
`default_nettype none

module primitive_depth_sorter_core
   import pds_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [DATA_W-1:0]     req_tdata,  // depth_key[31:0], prim_index[41:32]
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // opcode[1:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [DATA_W-1:0]          rsp_tdata,  // out_depth[31:0], out_index[41:32]
   output logic [RSP_USER_W-1:0]      rsp_tuser   // valid_res[0], overflowed[1]
);

   opcode_type   op;
   logic         req_beat;
   logic         full;
   cell_cmd_type cmd;

   key_type             cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_valid;
   logic [CAPACITY-1:0] cell_gt;

   logic                  overflow_ff, overflow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   assign op         = opcode_type'(req_tuser);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign full       = cell_valid[CAPACITY-1];

   assign cmd.insert = req_beat && (op == OP_INSERT) && !full;
   assign cmd.pop    = req_beat && (op == OP_POP);
   assign cmd.clear  = req_beat && (op == OP_CLEAR);
   assign cmd.key    = pack_key(req_tdata[DEPTH_W-1:0],
                                req_tdata[KEY_W-1:DEPTH_W]);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type p_entry, n_entry;
      logic    p_valid, p_gt, n_valid;
      if (i == 0) begin : g_first
         assign p_entry = '0;
         assign p_valid = 1'b0;
         assign p_gt    = 1'b0;
      end else begin : g_mid
         assign p_entry = cell_entry[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_gt    = cell_gt[i-1];
      end
      if (i == CAPACITY-1) begin : g_last
         assign n_entry = '0;
         assign n_valid = 1'b0;
      end else begin : g_inner
         assign n_entry = cell_entry[i+1];
         assign n_valid = cell_valid[i+1];
      end
      pds_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_entry (p_entry),
         .prev_valid (p_valid),
         .prev_gt    (p_gt),
         .next_entry (n_entry),
         .next_valid (n_valid),
         .entry      (cell_entry[i]),
         .valid      (cell_valid[i]),
         .gt         (cell_gt[i])
      );
   end

   always_comb begin
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.clear) begin
         overflow_in = 1'b0;
      end else if (req_beat && (op == OP_INSERT) && full) begin
         overflow_in = 1'b1;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = {overflow_ff, cell_valid[0]};
         if (cell_valid[0]) begin
            rsp_data_in = {{(DATA_W-KEY_W){1'b0}}, key_index(cell_entry[0]),
                           key_depth(cell_entry[0])};
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // occupied cells always form a prefix of the chain
   assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + 1'b1) & cell_valid) == '0)
      else $error("occupancy is not a prefix");

   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (!cell_valid[0] && !overflow_ff))
      else $error("clear left entries or overflow");

   assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> cell_valid[0])
      else $error("insert left list empty");

   assert property (@(posedge clock) disable iff (reset)
      (req_beat && (op == OP_INSERT) && full) |=> overflow_ff)
      else $error("dropped insert did not flag overflow");

endmodule

`default_nettype wire

### rtl/pds_cell.sv
// One cell of the sorting chain: holds one entry and its occupancy bit.
// Depends on pds_pkg; instantiated in a row by primitive_depth_sorter_core.
`default_nettype none

module pds_cell
   import pds_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire key_type      prev_entry,
   input  wire logic         prev_valid,
   input  wire logic         prev_gt,
   input  wire key_type      next_entry,
   input  wire logic         next_valid,
   output key_type           entry,
   output logic              valid,
   output logic              gt
);

   key_type entry_ff, entry_in;
   logic    valid_ff, valid_in;

   // empty cells count as larger than any key
   assign gt    = !valid_ff || (entry_ff > cmd.key);
   assign entry = entry_ff;
   assign valid = valid_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.pop) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (cmd.insert && gt) begin
         if (!prev_gt) begin
            entry_in = cmd.key;
            valid_in = 1'b1;
         end else begin
            entry_in = prev_entry;
            valid_in = prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
